### hw/rtl/lvs_pkg.sv
// Shared types and constants for the Legendre value and slope evaluator.
// Used by every module of the block; depends on nothing.
package lvs_pkg;

  localparam int FRAC_BITS = 30;
  localparam int MAX_ORDER = 63;
  localparam int ORD_W     = 6;
  localparam int PT_W      = 32;
  localparam int OUT_W     = 48;
  localparam int EPS_W     = 21;
  localparam int CUR_W     = 36;
  localparam int PRD_W     = 40;
  localparam int NUM_W     = 48;
  localparam int SN_W      = 42;
  localparam int DV_W      = 33;
  localparam int Q_W       = 50;
  localparam int DIG_W     = 8;
  localparam int DIG_N     = NUM_W / DIG_W;

  localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);

  typedef struct packed {
    logic        [ORD_W-1:0] order;
    logic signed [PT_W-1:0]  point;
  } lvs_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic signed [OUT_W-1:0] slope;
    logic                    saturated;
  } lvs_out_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic over;
  } lvs_div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMUL,
    ST_RCOMB,
    ST_RDIV,
    ST_SMUL,
    ST_SNUM,
    ST_SDEN,
    ST_SDIV,
    ST_FIN,
    ST_OUT
  } lvs_state_t;

endpackage

### hw/rtl/lvs_mul.sv
// Shared fixed-point multiplier: signed product shifted right by the fraction
// width, rounded on the magnitude. Depends on lvs_pkg.
module lvs_mul (
  input  logic signed [lvs_pkg::PT_W-1:0]  a,
  input  logic signed [lvs_pkg::CUR_W-1:0] b,
  output logic signed [lvs_pkg::PRD_W-1:0] p
);

  localparam int FW = lvs_pkg::PT_W + lvs_pkg::CUR_W + 1;
  localparam int MW = FW - lvs_pkg::FRAC_BITS;

  logic [lvs_pkg::PT_W-1:0]  ma;
  logic [lvs_pkg::CUR_W-1:0] mb;
  logic [FW-1:0]             full;
  logic [FW-1:0]             rnd;
  logic [lvs_pkg::PRD_W-1:0] mag;

  always_comb begin
    ma   = a[lvs_pkg::PT_W-1] ? (~a + 1'b1) : a;
    mb   = b[lvs_pkg::CUR_W-1] ? (~b + 1'b1) : b;
    full = FW'(ma) * FW'(mb);
    rnd  = full + (FW'(1) << (lvs_pkg::FRAC_BITS - 1));
    mag  = lvs_pkg::PRD_W'(rnd[FW-1:lvs_pkg::FRAC_BITS]);
    p    = (a[lvs_pkg::PT_W-1] != b[lvs_pkg::CUR_W-1]) ? $signed(~mag + 1'b1) : $signed(mag);
  end

endmodule

### hw/rtl/lvs_ldiv.sv
// Restoring long divider, one quotient bit a cycle, with round-half-up on the
// final remainder and a sticky overflow flag. Depends on lvs_pkg.
module lvs_ldiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lvs_pkg::SN_W-1:0]    dvd,
  input  logic [lvs_pkg::DV_W-1:0]    dvs,
  output logic [lvs_pkg::Q_W:0]       quo,
  output lvs_pkg::lvs_div_stat_t      stat
);

  localparam int STEPS = lvs_pkg::SN_W + lvs_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int DW    = lvs_pkg::DV_W;
  localparam int QW    = lvs_pkg::Q_W;

  logic [STEPS-1:0] sh_r, sh_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             over_r, over_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      rr;
  logic [DW:0]      two;
  logic             ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    q_r    <= q_nxt;
    over_r <= over_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    over_nxt = over_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rr       = {rem_r, sh_r[STEPS-1]};
    ge       = (rr >= {1'b0, dvs_r});
    if (start) begin
      sh_nxt   = {dvd, {lvs_pkg::FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dvs_nxt  = dvs;
      q_nxt    = '0;
      over_nxt = 1'b0;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt   = {sh_r[STEPS-2:0], 1'b0};
      rem_nxt  = ge ? DW'(rr - {1'b0, dvs_r}) : DW'(rr);
      q_nxt    = {q_r[QW-2:0], ge};
      over_nxt = over_r | q_r[QW-1];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    two       = {rem_r, 1'b0};
    quo       = (QW+1)'(q_r) + (QW+1)'(two >= {1'b0, dvs_r});
    stat.busy = busy_r;
    stat.done = done_r;
    stat.over = over_r;
  end

endmodule

### hw/rtl/legendre_value_and_slope_top.sv
// Top level of the Legendre value and slope evaluator: sequencer, recurrence
// datapath and result register. Depends on lvs_pkg, lvs_mul and lvs_ldiv.
//
//  Port group | Direction | Contents
//  in_        | request   | lvs_in_t: order, point (valid/ready)
//  out_       | result    | lvs_out_t: value, slope, saturated (valid/ready)
//  cfg_       | write     | boundary_epsilon, 21 bits, written when cfg_we is high
//
// Degrees zero and one go from idle straight to the finish state before out_valid rises.
// Degree n of two or more runs one recurrence step per degree from two to n (multiplier,
// combine and digit-divider states), then the slope states, whose division runs in the
// bit-serial long divider, before out_valid rises.
// Reset sets boundary_epsilon to one and empties the block. One request is held at a
// time: in_ready is high only when the block is empty, and a result waits for out_ready.
module legendre_value_and_slope_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lvs_pkg::lvs_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lvs_pkg::lvs_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [lvs_pkg::EPS_W-1:0]     cfg_wdata
);

  localparam int PT_W  = lvs_pkg::PT_W;
  localparam int CUR_W = lvs_pkg::CUR_W;
  localparam int PRD_W = lvs_pkg::PRD_W;
  localparam int NUM_W = lvs_pkg::NUM_W;
  localparam int SN_W  = lvs_pkg::SN_W;
  localparam int DV_W  = lvs_pkg::DV_W;
  localparam int Q_W   = lvs_pkg::Q_W;
  localparam int OUT_W = lvs_pkg::OUT_W;
  localparam int ORD_W = lvs_pkg::ORD_W;
  localparam int DIG_W = lvs_pkg::DIG_W;
  localparam int DC_W  = $clog2(lvs_pkg::DIG_N);

  localparam logic signed [PT_W-1:0]  ONE_PT  = PT_W'(lvs_pkg::ONE_FX);
  localparam logic signed [CUR_W-1:0] ONE_CUR = CUR_W'(lvs_pkg::ONE_FX);
  localparam logic signed [PRD_W-1:0] ONE_PRD = PRD_W'(lvs_pkg::ONE_FX);
  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(lvs_pkg::ONE_FX);
  localparam logic signed [OUT_W-1:0] SAT_HI  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_LO  = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [Q_W:0] LIM_POS = (Q_W+1)'((64'd1 << (OUT_W-1)) - 64'd1);
  localparam logic [Q_W:0] LIM_NEG = (Q_W+1)'(64'd1 << (OUT_W-1));
  localparam logic [ORD_W-1:0] N_MAX = ORD_W'(lvs_pkg::MAX_ORDER);

  lvs_pkg::lvs_state_t state_r, state_nxt;
  logic [lvs_pkg::EPS_W-1:0] eps_r;

  logic [ORD_W-1:0]        n_r, n_nxt;
  logic [ORD_W-1:0]        i_r, i_nxt;
  logic signed [PT_W-1:0]  x_r, x_nxt;
  logic signed [PT_W-1:0]  xc_r, xc_nxt;
  logic signed [CUR_W-1:0] cur_r, cur_nxt;
  logic signed [CUR_W-1:0] prev_r, prev_nxt;
  logic signed [PRD_W-1:0] prod_r, prod_nxt;
  logic [NUM_W-1:0]        dd_r, dd_nxt;
  logic [ORD_W-1:0]        drem_r, drem_nxt;
  logic [DC_W-1:0]         dcnt_r, dcnt_nxt;
  logic                    nneg_r, nneg_nxt;
  logic signed [SN_W-1:0]  snum_r, snum_nxt;
  logic                    sneg_r, sneg_nxt;
  logic                    szero_r, szero_nxt;
  lvs_pkg::lvs_out_t       out_r, out_nxt;

  logic signed [PT_W-1:0]  mul_a;
  logic signed [CUR_W-1:0] mul_b;
  logic signed [PRD_W-1:0] mul_p;

  logic                    div_start;
  logic [SN_W-1:0]         div_dvd;
  logic [DV_W-1:0]         div_dvs;
  logic [Q_W:0]            div_quo;
  lvs_pkg::lvs_div_stat_t  div_stat;

  logic [ORD_W-1:0]        n_in;
  logic [6:0]              k1;
  logic [ORD_W-1:0]        k2;
  logic signed [NUM_W-1:0] t1, t2, num;
  logic [NUM_W-1:0]        num_mag;
  logic [ORD_W-1:0]        r;
  logic [ORD_W:0]          rr;
  logic [DIG_W-1:0]        qb;
  logic signed [PRD_W-1:0] pm;
  logic signed [PRD_W:0]   diff;
  logic signed [PRD_W-1:0] d;
  logic [PRD_W-1:0]        dmag;
  logic [PT_W-1:0]         xmag;
  logic                    near_zero;
  logic                    dneg;
  logic signed [PT_W:0]    xm1, xp1;
  logic [PT_W:0]           xm1_mag, xp1_mag;
  logic                    bnd_p, bnd_m;
  logic [12:0]             nn;
  logic signed [OUT_W-1:0] closed;
  logic                    over_all;
  logic signed [OUT_W-1:0] sl;
  logic                    sat;

  lvs_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  lvs_ldiv u_ldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lvs_pkg::ST_IDLE;
      eps_r   <= lvs_pkg::EPS_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    x_r     <= x_nxt;
    xc_r    <= xc_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    prod_r  <= prod_nxt;
    dd_r    <= dd_nxt;
    drem_r  <= drem_nxt;
    dcnt_r  <= dcnt_nxt;
    nneg_r  <= nneg_nxt;
    snum_r  <= snum_nxt;
    sneg_r  <= sneg_nxt;
    szero_r <= szero_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    x_nxt     = x_r;
    xc_nxt    = xc_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    prod_nxt  = prod_r;
    dd_nxt    = dd_r;
    drem_nxt  = drem_r;
    dcnt_nxt  = dcnt_r;
    nneg_nxt  = nneg_r;
    snum_nxt  = snum_r;
    sneg_nxt  = sneg_r;
    szero_nxt = szero_r;
    out_nxt   = out_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;

    mul_a = x_r;
    mul_b = cur_r;

    n_in = (in_data.order > N_MAX) ? N_MAX : in_data.order;

    k1      = {i_r, 1'b0} - 7'd1;
    k2      = i_r - 1'b1;
    t1      = NUM_W'($signed({1'b0, k1})) * NUM_W'(prod_r);
    t2      = NUM_W'($signed({1'b0, k2})) * NUM_W'(prev_r);
    num     = t1 - t2;
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    r  = drem_r;
    qb = '0;
    rr = '0;
    for (int k = 0; k < DIG_W; k++) begin
      rr = {r, dd_r[NUM_W-1-k]};
      if (rr >= {1'b0, i_r}) begin
        r             = ORD_W'(rr - {1'b0, i_r});
        qb[DIG_W-1-k] = 1'b1;
      end else begin
        r = ORD_W'(rr);
      end
    end

    pm   = (n_r == ORD_W'(2)) ? PRD_W'(x_r) : PRD_W'(prev_r);
    diff = (PRD_W+1)'(prod_r) - (PRD_W+1)'(pm);

    d         = prod_r - ONE_PRD;
    dmag      = d[PRD_W-1] ? PRD_W'(-d) : PRD_W'(d);
    xmag      = x_r[PT_W-1] ? (~x_r + 1'b1) : x_r;
    near_zero = (dmag < PRD_W'(eps_r)) || (d == '0);
    dneg      = near_zero ? x_r[PT_W-1] : d[PRD_W-1];
    div_dvs   = near_zero ? {xmag, 1'b0} : DV_W'(dmag);
    div_dvd   = snum_r[SN_W-1] ? SN_W'(-snum_r) : SN_W'(snum_r);

    xm1     = (PT_W+1)'(x_r) - (PT_W+1)'(ONE_PT);
    xp1     = (PT_W+1)'(x_r) + (PT_W+1)'(ONE_PT);
    xm1_mag = xm1[PT_W] ? (PT_W+1)'(-xm1) : (PT_W+1)'(xm1);
    xp1_mag = xp1[PT_W] ? (PT_W+1)'(-xp1) : (PT_W+1)'(xp1);
    bnd_p   = xm1_mag < (PT_W+1)'(eps_r);
    bnd_m   = xp1_mag < (PT_W+1)'(eps_r);
    nn      = 13'(n_r) * (13'(n_r) + 13'd1);
    closed  = OUT_W'(nn >> 1) <<< lvs_pkg::FRAC_BITS;

    over_all = div_stat.over | div_quo[Q_W];
    sat      = 1'b0;
    if (n_r == '0) begin
      sl = '0;
    end else if (n_r == ORD_W'(1)) begin
      sl = ONE_OUT;
    end else if (bnd_p) begin
      sl = closed;
    end else if (bnd_m) begin
      sl = n_r[0] ? closed : -closed;
    end else if (szero_r) begin
      sl = '0;
    end else if (sneg_r) begin
      if (over_all || div_quo > LIM_NEG) begin
        sl  = SAT_LO;
        sat = 1'b1;
      end else begin
        sl = -(OUT_W'(div_quo));
      end
    end else begin
      if (over_all || div_quo > LIM_POS) begin
        sl  = SAT_HI;
        sat = 1'b1;
      end else begin
        sl = OUT_W'(div_quo);
      end
    end

    unique case (state_r)
      lvs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          n_nxt    = n_in;
          x_nxt    = in_data.point;
          if (in_data.point > ONE_PT) begin
            xc_nxt = ONE_PT;
          end else if (in_data.point < -ONE_PT) begin
            xc_nxt = -ONE_PT;
          end else begin
            xc_nxt = in_data.point;
          end
          prev_nxt = ONE_CUR;
          cur_nxt  = CUR_W'(xc_nxt);
          i_nxt    = ORD_W'(2);
          state_nxt = (n_in < ORD_W'(2)) ? lvs_pkg::ST_FIN : lvs_pkg::ST_RMUL;
        end
      end
      lvs_pkg::ST_RMUL: begin
        mul_a     = xc_r;
        mul_b     = cur_r;
        prod_nxt  = mul_p;
        state_nxt = lvs_pkg::ST_RCOMB;
      end
      lvs_pkg::ST_RCOMB: begin
        dd_nxt    = num_mag + NUM_W'(i_r >> 1);
        nneg_nxt  = num[NUM_W-1];
        drem_nxt  = '0;
        dcnt_nxt  = '0;
        state_nxt = lvs_pkg::ST_RDIV;
      end
      lvs_pkg::ST_RDIV: begin
        dd_nxt   = {dd_r[NUM_W-DIG_W-1:0], qb};
        drem_nxt = r;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DC_W'(lvs_pkg::DIG_N - 1)) begin
          prev_nxt = cur_r;
          cur_nxt  = nneg_r ? CUR_W'(-dd_nxt) : CUR_W'(dd_nxt);
          if (i_r == n_r) begin
            state_nxt = lvs_pkg::ST_SMUL;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = lvs_pkg::ST_RMUL;
          end
        end
      end
      lvs_pkg::ST_SMUL: begin
        mul_a     = x_r;
        mul_b     = cur_r;
        prod_nxt  = mul_p;
        state_nxt = lvs_pkg::ST_SNUM;
      end
      lvs_pkg::ST_SNUM: begin
        snum_nxt  = SN_W'($signed({1'b0, n_r})) * SN_W'(diff);
        mul_a     = x_r;
        mul_b     = CUR_W'(x_r);
        prod_nxt  = mul_p;
        state_nxt = lvs_pkg::ST_SDEN;
      end
      lvs_pkg::ST_SDEN: begin
        sneg_nxt  = snum_r[SN_W-1] ^ dneg;
        szero_nxt = near_zero && (x_r == '0);
        div_start = !(near_zero && (x_r == '0));
        state_nxt = (near_zero && (x_r == '0)) ? lvs_pkg::ST_FIN : lvs_pkg::ST_SDIV;
      end
      lvs_pkg::ST_SDIV: begin
        if (div_stat.done) begin
          state_nxt = lvs_pkg::ST_FIN;
        end
      end
      lvs_pkg::ST_FIN: begin
        if (n_r == '0) begin
          out_nxt.value = ONE_OUT;
        end else if (n_r == ORD_W'(1)) begin
          out_nxt.value = OUT_W'(x_r);
        end else begin
          out_nxt.value = OUT_W'(cur_r);
        end
        out_nxt.slope     = sl;
        out_nxt.saturated = sat;
        state_nxt         = lvs_pkg::ST_OUT;
      end
      lvs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = lvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lvs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_data = out_r;

endmodule
